### hdl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Types and constants shared by the linear interpolation resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 32;
  localparam int FRAC_W   = 24;
  // position carries one extra bit: a run can end just past 2^32
  localparam int POS_W    = STEP_W + 1;
  localparam int INT_W    = POS_W - FRAC_W;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int ACC_W    = SAMPLE_W + 2;
  localparam int CNT_W    = $clog2(FRAC_W);
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CHCNT_W    = 2;

  localparam logic [STEP_W-1:0]    STEP_RESET   = 32'h0100_0000;
  localparam logic [STEP_W-1:0]    MIN_STEP     = 32'h0004_0000;
  localparam logic [CHCNT_W-1:0]   CHCNT_RESET  = 2'd2;
  localparam logic [CHCNT_W-1:0]   CH_MONO      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANS  = 1'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // control of the serial multiply-interpolate units
  typedef struct packed {
    logic load;     // capture difference, clear accumulator
    logic shift;    // consume one multiplier bit
    logic mul_bit;  // current fraction bit, LSB first
  } lrs_mul_ctrl_t;

endpackage : lrs_pkg

`default_nettype wire

### hdl/lrs_in_if.sv
// ----------------------------------------------------------------------------
// lrs_in_if
// Source frame channel: valid/ready with one stereo frame per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrs_in_if;
  import lrs_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_ch0;
  sample_t sample_ch1;

  modport source (output valid, output sample_ch0, output sample_ch1, input ready);
  modport sink   (input valid, input sample_ch0, input sample_ch1, output ready);
endinterface : lrs_in_if

`default_nettype wire

### hdl/lrs_out_if.sv
// ----------------------------------------------------------------------------
// lrs_out_if
// Result channel: valid/ready with one interpolated frame per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrs_out_if;
  import lrs_pkg::*;

  logic    valid;
  logic    ready;
  sample_t out_ch0;
  sample_t out_ch1;
  logic    nonsilent;
  logic    last;

  modport source (output valid, output out_ch0, output out_ch1, output nonsilent,
                  output last, input ready);
  modport sink   (input valid, input out_ch0, input out_ch1, input nonsilent,
                  input last, output ready);
endinterface : lrs_out_if

`default_nettype wire

### hdl/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Stereo linear-interpolation sample rate converter with a Q9.24 phase
// accumulator and bit-serial interpolation.
// ----------------------------------------------------------------------------
//  Channel     Direction  Transaction
//  in_frame    sink       one source frame (sample_ch0, sample_ch1)
//  out_result  source     one output frame (out_ch0, out_ch1, nonsilent, last)
//  cfg_*       write      step ratio (index 0), active channels (index 1)
//
//  Each result passes a load step, then the serial multiplier, one bit
//  of the Q9.24 position's fraction per cycle, then an issue step.
//  A frame yields up to 64 results.
//  Reset is synchronous; the first frame after reset only primes the state.
//  A stalled result holds the issue step; the next frame is taken while the
//  last result of the previous frame still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler (
  input  wire                             clk,
  input  wire                             rst_n,
  lrs_in_if.sink                          in_frame,
  lrs_out_if.source                       out_result,
  input  wire                             cfg_we,
  input  wire [lrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [lrs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lrs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [STEP_W-1:0]   step_ratio_r;
  logic [CHCNT_W-1:0]  chcnt_r;
  logic                primed_r;
  logic [POS_W-1:0]    pos_r;
  sample_t             prev0_r, prev1_r;
  sample_t             new0_r, new1_r;
  logic [FRAC_W-1:0]   frac_sr_r;
  logic [CNT_W-1:0]    bit_cnt_r;

  logic                out_valid_r;
  sample_t             out_ch0_r, out_ch1_r;
  logic                nonsilent_r, last_r;

  logic [STEP_W-1:0]   step_eff;
  logic [POS_W-1:0]    pos_sum;
  logic [POS_W-1:0]    pos_sum_wrap;
  logic [POS_W-1:0]    pos_wrap;
  logic                crosses;
  logic                in_fire;
  logic                issue;
  logic                mono;
  lrs_mul_ctrl_t       mul_ctrl;
  sample_t             res0, res1, res1_sel;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ratio_r <= STEP_RESET;
      chcnt_r      <= CHCNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_RATIO: step_ratio_r <= cfg_wdata[STEP_W-1:0];
        REG_NUM_CHANS:  chcnt_r      <= cfg_wdata[CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign step_eff     = (step_ratio_r < MIN_STEP) ? MIN_STEP : step_ratio_r;
  assign pos_sum      = pos_r + POS_W'(step_eff);
  assign crosses      = (pos_sum[POS_W-1:FRAC_W] != '0);
  // subtracting 1.0 touches the integer part only
  assign pos_sum_wrap = {pos_sum[POS_W-1:FRAC_W] - INT_W'(1), pos_sum[FRAC_W-1:0]};
  assign pos_wrap     = {pos_r[POS_W-1:FRAC_W] - INT_W'(1), pos_r[FRAC_W-1:0]};
  assign mono         = (chcnt_r == CH_MONO);

  assign in_frame.ready = (state_r == S_IDLE);
  assign in_fire        = in_frame.valid && in_frame.ready;
  assign issue          = (state_r == S_DONE) && (!out_valid_r || out_result.ready);

  always_comb begin
    mul_ctrl.load    = (state_r == S_LOAD);
    mul_ctrl.shift   = (state_r == S_MUL);
    mul_ctrl.mul_bit = frac_sr_r[0];
  end

  lrs_serial_lerp u_lerp_ch0 (
    .clk      (clk),
    .ctrl     (mul_ctrl),
    .prev_i   (prev0_r),
    .next_i   (new0_r),
    .result_o (res0)
  );

  lrs_serial_lerp u_lerp_ch1 (
    .clk      (clk),
    .ctrl     (mul_ctrl),
    .prev_i   (prev1_r),
    .next_i   (new1_r),
    .result_o (res1)
  );

  assign res1_sel = mono ? '0 : res1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && primed_r && (pos_r[POS_W-1:FRAC_W] == '0)) state_nxt = S_LOAD;
      end
      S_LOAD: state_nxt = S_MUL;
      S_MUL: begin
        if (bit_cnt_r == CNT_W'(FRAC_W - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (issue) state_nxt = crosses ? S_IDLE : S_LOAD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      primed_r <= 1'b0;
      pos_r    <= '0;
      prev0_r  <= '0;
      prev1_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        if (!primed_r) begin
          prev0_r  <= in_frame.sample_ch0;
          prev1_r  <= in_frame.sample_ch1;
          pos_r    <= '0;
          primed_r <= 1'b1;
        end else if (pos_r[POS_W-1:FRAC_W] != '0) begin
          // frame yields nothing
          prev0_r <= in_frame.sample_ch0;
          prev1_r <= in_frame.sample_ch1;
          pos_r   <= pos_wrap;
        end
      end
      if (issue) begin
        if (crosses) begin
          pos_r   <= pos_sum_wrap;
          prev0_r <= new0_r;
          prev1_r <= new1_r;
        end else begin
          pos_r   <= pos_sum;
        end
      end
    end
  end

  // frame capture and fraction shift register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      new0_r <= in_frame.sample_ch0;
      new1_r <= in_frame.sample_ch1;
    end
    if (state_r == S_LOAD) begin
      frac_sr_r <= pos_r[FRAC_W-1:0];
      bit_cnt_r <= '0;
    end else if (state_r == S_MUL) begin
      frac_sr_r <= frac_sr_r >> 1;
      bit_cnt_r <= bit_cnt_r + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (issue) begin
      out_valid_r <= 1'b1;
    end else if (out_result.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_ch0_r   <= res0;
      out_ch1_r   <= res1_sel;
      nonsilent_r <= (res0 != '0) || (res1_sel != '0);
      last_r      <= crosses;
    end
  end

  assign out_result.valid     = out_valid_r;
  assign out_result.out_ch0   = out_ch0_r;
  assign out_result.out_ch1   = out_ch1_r;
  assign out_result.nonsilent = nonsilent_r;
  assign out_result.last      = last_r;

  // checks
  a_pos_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pos_r[POS_W-1])
    else $error("phase position exceeds 32 bits between frames");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (bit_cnt_r < CNT_W'(FRAC_W)))
    else $error("serial multiply bit count out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && crosses) |=> (state_r == S_IDLE) && out_result.last)
    else $error("final result of a frame did not return to idle");

  a_run_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (pos_r[POS_W-1:FRAC_W] == '0))
    else $error("interpolation started with position at or above 1.0");

endmodule : linear_interp_resampler

`default_nettype wire

### hdl/lrs_serial_lerp.sv
// ----------------------------------------------------------------------------
// lrs_serial_lerp
// Bit-serial interpolator: prev + floor((next - prev) * frac / 2^24),
// one fraction bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_serial_lerp (
  input  wire                         clk,
  input  wire lrs_pkg::lrs_mul_ctrl_t ctrl,
  input  wire lrs_pkg::sample_t       prev_i,
  input  wire lrs_pkg::sample_t       next_i,
  output lrs_pkg::sample_t            result_o
);
  import lrs_pkg::*;

  logic signed [DIFF_W-1:0] diff_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  res_full;

  // acc holds floor(partial product / 2^k); flooring at each step equals
  // flooring the full product once
  always_comb begin
    addend  = ctrl.mul_bit ? ACC_W'(diff_r) : '0;
    sum     = acc_r + addend;
    acc_nxt = sum >>> 1;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      diff_r <= DIFF_W'(next_i) - DIFF_W'(prev_i);
      acc_r  <= '0;
    end else if (ctrl.shift) begin
      acc_r  <= acc_nxt;
    end
  end

  // result lies between the two samples, so the low bits are exact
  assign res_full = ACC_W'(prev_i) + acc_r;
  assign result_o = res_full[SAMPLE_W-1:0];

endmodule : lrs_serial_lerp

`default_nettype wire
